### sv/tss_pkg.sv
`timescale 1ns / 1ps
// tss_pkg: shared widths, scaling and calibration constants, control types
// for the temperature sensor smoothing block. No dependencies.
package tss_pkg;

    localparam int TSS_WINDOW_TAPS = 5;

    localparam int SAMPLE_W = 10;
    localparam int ACC_W    = 12;
    localparam int CNT_W    = 2;
    localparam int RAW_W    = 10;
    localparam int TEMP_W   = 17;

    localparam logic [CNT_W-1:0] LAST_OF_GROUP = 2'd3;

    localparam logic signed [TEMP_W-1:0] SCALE      = 17'sd48;
    localparam logic signed [TEMP_W-1:0] OFFSET     = 17'sd6000;
    localparam logic signed [TEMP_W-1:0] KNEE       = 17'sd2500;
    localparam logic signed [TEMP_W-1:0] LO_BASE    = 17'sd698;
    localparam logic signed [TEMP_W-1:0] LO_BIAS    = 17'sd3090;
    localparam logic signed [TEMP_W-1:0] LO_DIV     = 17'sd55;
    localparam logic signed [TEMP_W-1:0] HI_BASE    = 17'sd550;
    localparam logic signed [TEMP_W-1:0] HI_DIV     = 17'sd75;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -17'sd6750;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 17'sd42013;

    typedef struct packed {
        logic fill;
        logic shift;
    } t_win_ctl;

endpackage

### sv/temperature_sensor_smoothing_top.sv
`timescale 1ns / 1ps
// temperature_sensor_smoothing_top: sample grouping, window chain and
// calibration pipeline. Depends on tss_pkg, tss_window and tss_calib.
//
// One sample beat is taken every cycle while ready is high. Every fourth
// sample closes a group; the first group after reset only fills the window,
// each later group gives one result beat whose valid follows the closing sample
// through the register stages in order: the window sum is loaded at the edge
// that takes it, then mean, scale and calibration. All stages move together,
// so ready falls only while a result waits in the output register and the
// downstream side is not taking it.
module temperature_sensor_smoothing_top
    import tss_pkg::*;
#(
    parameter int WINDOW_TAPS = TSS_WINDOW_TAPS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SAMPLE_W-1:0]      i_sample,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic [RAW_W-1:0]         o_filtered_raw
);

    localparam int SUM_W = RAW_W + $clog2(WINDOW_TAPS);

    logic [ACC_W-1:0] r_sum;
    logic [ACC_W-1:0] n_sum;
    logic [CNT_W-1:0] r_count;
    logic             r_primed;
    logic             r_total_v;
    logic             w_en;
    logic             w_accept;
    logic             w_close;
    logic [RAW_W-1:0] w_raw;
    t_win_ctl         w_ctl;
    logic [SUM_W-1:0] w_total;

    assign w_en     = !o_valid || i_ready;
    assign o_ready  = w_en;
    assign w_accept = i_valid && w_en;
    assign w_close  = w_accept && (r_count == LAST_OF_GROUP);
    assign n_sum    = r_sum + ACC_W'(i_sample);
    assign w_raw    = n_sum[ACC_W-1:2];

    always_comb begin
        w_ctl.fill  = w_close && !r_primed;
        w_ctl.shift = w_close && r_primed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_primed  <= 1'b0;
            r_total_v <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_close) begin
                    r_sum    <= '0;
                    r_count  <= '0;
                    r_primed <= 1'b1;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + 1'b1;
                end
            end
            if (w_en) begin
                r_total_v <= w_ctl.shift;
            end
        end
    end

    tss_window #(
        .WINDOW_TAPS (WINDOW_TAPS),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_raw   (w_raw),
        .o_total (w_total)
    );

    tss_calib #(
        .WINDOW_TAPS (WINDOW_TAPS),
        .SUM_W       (SUM_W)
    ) u_calib (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_total_v),
        .i_total (w_total),
        .o_valid (o_valid),
        .o_temp  (o_temperature_centi),
        .o_mean  (o_filtered_raw)
    );

    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("window lost its primed state");

    a_no_result_unprimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> !o_valid && !r_total_v)
        else $error("result before window was filled");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi >= TEMP_MIN) && (o_temperature_centi <= TEMP_MAX))
        else $error("calibrated temperature out of range");

endmodule

### sv/tss_cell.sv
`timescale 1ns / 1ps
// tss_cell: one window entry of the smoothing chain.
// Depends on tss_pkg.
module tss_cell
    import tss_pkg::*;
(
    input  logic             i_clk,
    input  t_win_ctl         i_ctl,
    input  logic [RAW_W-1:0] i_raw,
    input  logic [RAW_W-1:0] i_prev,
    output logic [RAW_W-1:0] o_entry
);

    logic [RAW_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_entry <= i_raw;
        end else if (i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

### sv/tss_window.sv
`timescale 1ns / 1ps
// tss_window: row of tss_cell entries with a running sum of the window.
// Depends on tss_pkg and tss_cell.
module tss_window
    import tss_pkg::*;
#(
    parameter int WINDOW_TAPS = TSS_WINDOW_TAPS,
    parameter int SUM_W       = RAW_W + $clog2(WINDOW_TAPS)
) (
    input  logic             i_clk,
    input  t_win_ctl         i_ctl,
    input  logic [RAW_W-1:0] i_raw,
    output logic [SUM_W-1:0] o_total
);

    logic [RAW_W-1:0] w_entry [WINDOW_TAPS];
    logic [SUM_W-1:0] r_total;
    logic [SUM_W-1:0] n_total;

    for (genvar g = 0; g < WINDOW_TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            tss_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_raw   (i_raw),
                .i_prev  (i_raw),
                .o_entry (w_entry[g])
            );
        end else begin : g_body
            tss_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_raw   (i_raw),
                .i_prev  (w_entry[g-1]),
                .o_entry (w_entry[g])
            );
        end
    end

    always_comb begin
        n_total = r_total;
        if (i_ctl.fill) begin
            n_total = SUM_W'(SUM_W'(i_raw) * SUM_W'(WINDOW_TAPS));
        end else if (i_ctl.shift) begin
            n_total = r_total + SUM_W'(i_raw) - SUM_W'(w_entry[WINDOW_TAPS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
    end

    assign o_total = r_total;

endmodule

### sv/tss_calib.sv
`timescale 1ns / 1ps
// tss_calib: mean, scale and piecewise calibration stages ending in the
// output register. Depends on tss_pkg.
module tss_calib
    import tss_pkg::*;
#(
    parameter int WINDOW_TAPS = TSS_WINDOW_TAPS,
    parameter int SUM_W       = RAW_W + $clog2(WINDOW_TAPS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [SUM_W-1:0]         i_total,
    output logic                     o_valid,
    output logic signed [TEMP_W-1:0] o_temp,
    output logic [RAW_W-1:0]         o_mean
);

    // reciprocal multiplies, exact over the reachable operand ranges
    localparam int MEAN_SHIFT = 18;
    localparam int MEAN_RECIP = (2**MEAN_SHIFT + WINDOW_TAPS - 1) / WINDOW_TAPS;
    localparam int MEAN_PW    = SUM_W + MEAN_SHIFT + 1;
    localparam int LO_SHIFT   = 20;
    localparam int LO_RECIP   = (2**LO_SHIFT + int'(LO_DIV) - 1) / int'(LO_DIV);
    localparam int HI_SHIFT   = 22;
    localparam int HI_RECIP   = (2**HI_SHIFT + int'(HI_DIV) - 1) / int'(HI_DIV);
    localparam int CAL_PW     = 2 * TEMP_W;
    localparam int QUO_W      = 12;

    logic                     r_mean_v;
    logic [RAW_W-1:0]         r_mean;
    logic                     r_d_v;
    logic signed [TEMP_W-1:0] r_d;
    logic [RAW_W-1:0]         r_d_mean;
    logic                     r_out_v;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [RAW_W-1:0]         r_out_mean;

    logic [MEAN_PW-1:0]       w_mean_prod;
    logic [RAW_W-1:0]         n_mean;
    logic signed [TEMP_W-1:0] n_d;
    logic signed [TEMP_W-1:0] w_lo_num;
    logic signed [TEMP_W-1:0] w_hi_num;
    logic [TEMP_W-1:0]        w_lo_mag;
    logic [TEMP_W-1:0]        w_hi_mag;
    logic [CAL_PW-1:0]        w_lo_prod;
    logic [CAL_PW-1:0]        w_hi_prod;
    logic [TEMP_W-1:0]        w_lo_quo;
    logic [TEMP_W-1:0]        w_hi_quo;
    logic signed [TEMP_W-1:0] q_lo;
    logic signed [TEMP_W-1:0] q_hi;
    logic signed [TEMP_W-1:0] n_temp;

    always_comb begin
        w_mean_prod = MEAN_PW'(i_total) * MEAN_PW'(MEAN_RECIP);
        n_mean      = w_mean_prod[MEAN_SHIFT +: RAW_W];
        n_d         = $signed({{(TEMP_W-RAW_W){1'b0}}, r_mean}) * SCALE - OFFSET;

        // truncating divisions toward zero on the magnitude
        w_lo_num  = r_d + LO_BIAS;
        w_hi_num  = r_d - KNEE;
        w_lo_mag  = w_lo_num[TEMP_W-1] ? $unsigned(-w_lo_num) : $unsigned(w_lo_num);
        w_hi_mag  = w_hi_num[TEMP_W-1] ? $unsigned(-w_hi_num) : $unsigned(w_hi_num);
        w_lo_prod = CAL_PW'(w_lo_mag) * CAL_PW'(LO_RECIP);
        w_hi_prod = CAL_PW'(w_hi_mag) * CAL_PW'(HI_RECIP);
        w_lo_quo  = {{(TEMP_W-QUO_W){1'b0}}, w_lo_prod[LO_SHIFT +: QUO_W]};
        w_hi_quo  = {{(TEMP_W-QUO_W){1'b0}}, w_hi_prod[HI_SHIFT +: QUO_W]};
        q_lo      = w_lo_num[TEMP_W-1] ? -$signed(w_lo_quo) : $signed(w_lo_quo);
        q_hi      = w_hi_num[TEMP_W-1] ? -$signed(w_hi_quo) : $signed(w_hi_quo);

        if (r_d <= KNEE) begin
            n_temp = r_d - (LO_BASE - q_lo);
        end else begin
            n_temp = r_d - (HI_BASE + q_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_v <= 1'b0;
            r_d_v    <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (i_en) begin
            r_mean_v <= i_valid;
            r_d_v    <= r_mean_v;
            r_out_v  <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mean     <= n_mean;
            r_d        <= n_d;
            r_d_mean   <= r_mean;
            r_out_temp <= n_temp;
            r_out_mean <= r_d_mean;
        end
    end

    assign o_valid = r_out_v;
    assign o_temp  = r_out_temp;
    assign o_mean  = r_out_mean;

endmodule

### test/tb_temperature_sensor_smoothing_top.sv
`timescale 1ns / 1ps
// tb_temperature_sensor_smoothing_top: self-checking bench for the smoothing block.
// A scoreboard class predicts each reading from the accepted samples; plain tasks
// drive samples with random gaps and back-pressure. Depends on tss_pkg.
module tb_temperature_sensor_smoothing_top;
    import tss_pkg::*;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [RAW_W-1:0]         raw;
    } reading_t;

    class smoothing_scoreboard;
        logic [ACC_W-1:0] group_sum;
        logic [CNT_W-1:0] group_cnt;
        logic [RAW_W-1:0] taps[TSS_WINDOW_TAPS];
        logic [2:0]       oldest;
        bit               primed;
        reading_t         expected_q[$];
        int               errors;

        function new();
            group_sum = '0;
            group_cnt = '0;
            foreach (taps[k]) taps[k] = '0;
            oldest = '0;
            primed = 1'b0;
            errors = 0;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [RAW_W-1:0] raw;
            int total;
            int mean;
            int d;
            reading_t r;
            group_sum = group_sum + ACC_W'(s);
            if (group_cnt != LAST_OF_GROUP) begin
                group_cnt = group_cnt + 1'b1;
                return;
            end
            raw = RAW_W'(group_sum >> 2);
            group_sum = '0;
            group_cnt = '0;
            if (!primed) begin
                foreach (taps[k]) taps[k] = raw;
                oldest = '0;
                primed = 1'b1;
                return;
            end
            if (oldest >= TSS_WINDOW_TAPS) oldest = '0;
            taps[oldest] = raw;
            oldest = oldest + 1'b1;
            if (oldest >= TSS_WINDOW_TAPS) oldest = '0;
            total = 0;
            foreach (taps[k]) total += int'(taps[k]);
            mean = total / TSS_WINDOW_TAPS;
            d = mean * int'(SCALE) - int'(OFFSET);
            if (d <= int'(KNEE))
                d = d - (int'(LO_BASE) - (d + int'(LO_BIAS)) / int'(LO_DIV));
            else
                d = d - (int'(HI_BASE) + (d - int'(KNEE)) / int'(HI_DIV));
            r.temp = TEMP_W'(d);
            r.raw = RAW_W'(mean);
            expected_q.push_back(r);
        endfunction

        function void check_reading(logic signed [TEMP_W-1:0] temp, logic [RAW_W-1:0] raw);
            reading_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected reading beat: temperature_centi %0d filtered_raw %0d",
                       temp, raw);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (temp !== e.temp) begin
                $error("temperature_centi expected %0d got %0d", e.temp, temp);
                errors++;
            end
            if (raw !== e.raw) begin
                $error("filtered_raw expected %0d got %0d", e.raw, raw);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int GROUPS_PER_PHASE = 104;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [SAMPLE_W-1:0]      i_sample;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [TEMP_W-1:0] o_temperature_centi;
    logic [RAW_W-1:0]         o_filtered_raw;

    smoothing_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int stalled_cycles;

    temperature_sensor_smoothing_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample            (i_sample),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_filtered_raw      (o_filtered_raw)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_reading(o_temperature_centi, o_filtered_raw);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_temperature_sensor_smoothing_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic send_group(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                              input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d);
        send_sample(a);
        send_sample(b);
        send_sample(c);
        send_sample(d);
    endtask

    // hold the sender off until every pending reading has come out
    task automatic drain_readings();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int base);
        int v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(1023);
            3:       v = ($urandom_range(1) != 0) ? 1023 : 0;
            default: v = base + $urandom_range(16) - 8;
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_W'(v);
    endfunction

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        int base;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int g = 0; g < GROUPS_PER_PHASE; g++) begin
            case ($urandom_range(3))
                0:       base = $urandom_range(185, 170);
                1:       base = ($urandom_range(1) != 0) ? $urandom_range(20) : 1023 - $urandom_range(20);
                default: base = $urandom_range(1023);
            endcase
            for (int k = 0; k < 4; k++) send_sample(pick_sample(base));
        end
        drain_readings();
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_sample = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stalled_cycles = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first group only fills the window, later ones walk it past the wrap
        send_group(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_group(10'd0, 10'd0, 10'd0, 10'd0);
        send_group(10'd177, 10'd177, 10'd177, 10'd177);
        send_group(10'd178, 10'd178, 10'd179, 10'd178);
        send_group(10'h2AA, 10'h155, 10'h2AA, 10'h155);
        send_group(10'd1023, 10'd0, 10'd1, 10'd512);
        drain_readings();
        repeat (3) send_group(10'd0, 10'd0, 10'd0, 10'd0);
        drain_readings();
        repeat (5) send_group(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        drain_readings();

        random_phase(16, 56);
        random_phase(56, 16);
        random_phase(0, 0);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (12) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_temperature_sensor_smoothing_top: PASS");
        else
            $display("tb_temperature_sensor_smoothing_top: FAIL");
        $finish;
    end

endmodule
